FILE: src/ttlr_pkg.sv
// ============================================================================
// TTL rewriter package
// Shared types, register codes and constants for the TTL match and
// decrement rewriter.
// ============================================================================
package ttlr_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned PosW  = 5;
    localparam int unsigned CfgIdxW = 1;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_MATCH_TTL  = 1'b0,
        CFG_LOWEST_TTL = 1'b1
    } cfg_index_t;

    localparam logic [ByteW-1:0] MATCH_TTL_RESET  = 8'd64;
    localparam logic [ByteW-1:0] LOWEST_TTL_RESET = 8'd15;

    localparam logic [15:0] TAG_ETHERTYPE  = 16'h8100;
    localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
    localparam logic [PosW-1:0] TAG_BYTES     = 5'd4;
    localparam logic [PosW-1:0] PLAIN_IP_BASE = 5'd14;
    localparam logic [PosW-1:0] TYPE_HI_POS   = 5'd12;
    localparam logic [PosW-1:0] TYPE_LO_POS   = 5'd13;
    localparam logic [PosW-1:0] TTL_OFFSET    = 5'd8;
    localparam logic [PosW-1:0] CHECK_HI_OFFSET = 5'd10;
    localparam logic [PosW-1:0] CHECK_LO_OFFSET = 5'd11;
    localparam logic [PosW-1:0] POS_MAX       = 5'd31;
    localparam logic [16:0] TTL_STEP   = 17'h0_0100;
    localparam logic [16:0] CHECK_FOLD = 17'h0_FFFF;

    typedef struct packed {
        logic [ByteW-1:0] in_byte;
        logic             in_last;
        logic             truncated;
    } item_t;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             out_last;
        logic             forward;
    } result_t;

    // Results produced by one input word: zero, one or two of them.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } edit_out_t;

endpackage

FILE: src/ttlr_ifs.sv
// ============================================================================
// TTL rewriter channels
// Valid/ready channel interfaces for the input stream, the result stream
// and the configuration write port.
// ============================================================================
interface ttlr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       truncated;

    modport source (output valid, output in_byte, output in_last, output truncated,
                    input ready);
    modport sink   (input valid, input in_byte, input in_last, input truncated,
                    output ready);
endinterface

interface ttlr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       forward;

    modport source (output valid, output out_byte, output out_last, output forward,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input forward,
                    output ready);
endinterface

interface ttlr_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] reg_index;
    logic [7:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: src/ttl_match_decrement_rewriter_core.sv
// ============================================================================
// TTL match and decrement rewriter
// Passes an Ethernet frame through byte by byte and, for a qualifying IPv4
// frame, decrements the TTL and patches the header checksum in flight.
// ============================================================================
// Usage:
//   in_ch carries one frame byte per word with its last and truncated marks.
//   out_ch returns every byte, TTL and checksum edited when the TTL equals
//   match_ttl, is at least lowest_ttl and no truncation mark came up to the
//   TTL byte. The first checksum byte yields no word and the second yields
//   two. The word with out_last high carries forward: 1 means inject the
//   edited frame, 0 means drop it.
//   cfg_ch writes match_ttl (index 0) or lowest_ttl (index 1); it is always
//   ready and is meant to be used only between frames, with the block idle.
// Timing:
//   A word is held in the input register, and its results are loaded into
//   the output register when it moves on, from where out_ch takes them. One
//   word is taken per cycle while out_ch is ready, except while the extra
//   result of the second checksum byte moves up from the spare result
//   register.
// Reset and stalls:
//   Reset empties both stages, clears all frame tracking and loads 64 and 15.
//   When out_ch stalls, the output and spare registers hold their words and
//   in_ch.ready falls once the input register is occupied; nothing is lost.
module ttl_match_decrement_rewriter_core (
    input  logic       clk,
    input  logic       rst_n,
    ttlr_in_if.sink    in_ch,
    ttlr_out_if.source out_ch,
    ttlr_cfg_if.sink   cfg_ch
);
    import ttlr_pkg::*;

    logic       cfg_wr;
    logic [7:0] match_ttl_reg;
    logic [7:0] lowest_ttl_reg;
    logic       inq_v_reg, inq_v_next;
    item_t      inq_reg;
    logic       in_acc;
    logic       advance;
    edit_out_t  res;

    // Configuration registers, written by index.
    assign cfg_ch.ready = 1'b1;
    assign cfg_wr = cfg_ch.valid && cfg_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_ttl_reg  <= MATCH_TTL_RESET;
            lowest_ttl_reg <= LOWEST_TTL_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index_t'(cfg_ch.reg_index))
                CFG_MATCH_TTL:  match_ttl_reg  <= cfg_ch.wr_data;
                CFG_LOWEST_TTL: lowest_ttl_reg <= cfg_ch.wr_data;
                default:        ;
            endcase
        end
    end

    // Input register: refills in the same cycle its word moves on.
    assign in_ch.ready = !inq_v_reg || advance;
    assign in_acc      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (in_acc)
        begin
            inq_v_next = 1'b1;
        end
        else if (advance)
        begin
            inq_v_next = 1'b0;
        end
        else
        begin
            inq_v_next = inq_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_v_reg <= 1'b0;
        end
        else
        begin
            inq_v_reg <= inq_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            inq_reg <= '{in_byte: in_ch.in_byte, in_last: in_ch.in_last,
                         truncated: in_ch.truncated};
        end
    end

    ttlr_edit u_edit (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (inq_reg),
        .match_ttl  (match_ttl_reg),
        .lowest_ttl (lowest_ttl_reg),
        .res        (res)
    );

    ttlr_outbuf u_outbuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .offer  (inq_v_reg),
        .res    (res),
        .take   (advance),
        .out_ch (out_ch)
    );

endmodule

FILE: src/ttlr_edit.sv
// ============================================================================
// TTL rewriter edit stage
// Tracks the frame layout, qualifies the TTL, edits TTL and checksum and
// forms the results of one input word.
// ============================================================================
module ttlr_edit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ttlr_pkg::item_t     item,
    input  logic [7:0]          match_ttl,
    input  logic [7:0]          lowest_ttl,
    output ttlr_pkg::edit_out_t res
);
    import ttlr_pkg::*;

    logic [PosW-1:0] byte_position_reg, byte_position_next;
    logic            vlan_seen_reg, vlan_seen_next;
    logic [7:0]      type_high_byte_reg, type_high_byte_next;
    logic            is_ipv4_reg, is_ipv4_next;
    logic            ttl_passed_reg, ttl_passed_next;
    logic            truncation_seen_reg, truncation_seen_next;
    logic            edit_done_reg, edit_done_next;
    logic [7:0]      held_check_byte_reg, held_check_byte_next;

    logic [PosW-1:0] base;
    logic [15:0]     type_word;
    logic [16:0]     check_sum;
    logic [16:0]     check_fold;
    logic [7:0]      ob;
    logic            fwd;
    logic            at_check_hi;
    logic            at_check_lo;

    always_comb
    begin
        base = vlan_seen_reg ? (PLAIN_IP_BASE + TAG_BYTES) : PLAIN_IP_BASE;
        type_word = {type_high_byte_reg, item.in_byte};
        at_check_hi = is_ipv4_reg && (byte_position_reg == base + CHECK_HI_OFFSET);
        at_check_lo = is_ipv4_reg && (byte_position_reg == base + CHECK_LO_OFFSET);

        byte_position_next   = byte_position_reg;
        vlan_seen_next       = vlan_seen_reg;
        type_high_byte_next  = type_high_byte_reg;
        is_ipv4_next         = is_ipv4_reg;
        ttl_passed_next      = ttl_passed_reg;
        truncation_seen_next = truncation_seen_reg | item.truncated;
        edit_done_next       = edit_done_reg;
        held_check_byte_next = held_check_byte_reg;
        ob                   = item.in_byte;

        if (byte_position_reg == TYPE_HI_POS
            || (vlan_seen_reg && byte_position_reg == TYPE_HI_POS + TAG_BYTES))
        begin
            type_high_byte_next = item.in_byte;
        end

        if (byte_position_reg == TYPE_LO_POS)
        begin
            if (type_word == TAG_ETHERTYPE)
            begin
                vlan_seen_next = 1'b1;
            end
            else if (type_word == IPV4_ETHERTYPE)
            begin
                is_ipv4_next = 1'b1;
            end
        end
        else if (vlan_seen_reg && byte_position_reg == TYPE_LO_POS + TAG_BYTES)
        begin
            if (type_word == IPV4_ETHERTYPE)
            begin
                is_ipv4_next = 1'b1;
            end
        end

        if (is_ipv4_reg && byte_position_reg == base + TTL_OFFSET
            && item.in_byte == match_ttl && item.in_byte >= lowest_ttl
            && !truncation_seen_next)
        begin
            ttl_passed_next = 1'b1;
            ob = item.in_byte - 8'd1;
        end

        // Incremental checksum update with end-around carry.
        check_sum  = {1'b0, held_check_byte_reg, item.in_byte} + TTL_STEP;
        check_fold = (check_sum >= CHECK_FOLD) ? (check_sum + 17'd1) : check_sum;

        res = '0;
        if (at_check_hi)
        begin
            held_check_byte_next = item.in_byte;
            if (item.in_last)
            begin
                res.count = 2'd1;
                res.first = '{out_byte: item.in_byte, out_last: 1'b1, forward: 1'b0};
            end
        end
        else if (at_check_lo)
        begin
            if (ttl_passed_reg)
            begin
                edit_done_next = 1'b1;
            end
            fwd = item.in_last && ttl_passed_reg && !truncation_seen_next;
            res.count = 2'd2;
            res.first = '{out_byte: ttl_passed_reg ? check_fold[15:8] : held_check_byte_reg,
                          out_last: 1'b0, forward: 1'b0};
            res.second = '{out_byte: ttl_passed_reg ? check_fold[7:0] : item.in_byte,
                           out_last: item.in_last, forward: fwd};
        end
        else
        begin
            fwd = item.in_last && ttl_passed_reg && edit_done_reg && !truncation_seen_next;
            res.count = 2'd1;
            res.first = '{out_byte: ob, out_last: item.in_last, forward: fwd};
        end
        fwd = 1'b0;

        if (item.in_last)
        begin
            byte_position_next   = '0;
            vlan_seen_next       = 1'b0;
            type_high_byte_next  = '0;
            is_ipv4_next         = 1'b0;
            ttl_passed_next      = 1'b0;
            truncation_seen_next = 1'b0;
            edit_done_next       = 1'b0;
        end
        else if (byte_position_reg < POS_MAX)
        begin
            byte_position_next = byte_position_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= '0;
            vlan_seen_reg       <= 1'b0;
            type_high_byte_reg  <= '0;
            is_ipv4_reg         <= 1'b0;
            ttl_passed_reg      <= 1'b0;
            truncation_seen_reg <= 1'b0;
            edit_done_reg       <= 1'b0;
        end
        else if (step)
        begin
            byte_position_reg   <= byte_position_next;
            vlan_seen_reg       <= vlan_seen_next;
            type_high_byte_reg  <= type_high_byte_next;
            is_ipv4_reg         <= is_ipv4_next;
            ttl_passed_reg      <= ttl_passed_next;
            truncation_seen_reg <= truncation_seen_next;
            edit_done_reg       <= edit_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held_check_byte_reg <= held_check_byte_next;
        end
    end

    // A frame can only qualify once its IP ethertype has been recognized.
    assert property (@(posedge clk) disable iff (!rst_n)
        ttl_passed_reg |-> is_ipv4_reg)
        else $error("ttl_passed set without an IPv4 frame");

    // The checksum is only rewritten for a frame whose TTL qualified.
    assert property (@(posedge clk) disable iff (!rst_n)
        edit_done_reg |-> ttl_passed_reg)
        else $error("checksum edited for a frame that did not qualify");

endmodule

FILE: src/ttlr_outbuf.sv
// ============================================================================
// TTL rewriter result buffer
// Two result registers: the head drives the output channel and the spare
// holds the second result of a checksum word.
// ============================================================================
module ttlr_outbuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                offer,
    input  ttlr_pkg::edit_out_t res,
    output logic                take,
    ttlr_out_if.source          out_ch
);
    import ttlr_pkg::*;

    logic    head_v_reg, head_v_next;
    logic    spare_v_reg, spare_v_next;
    result_t head_reg, head_next;
    result_t spare_reg, spare_next;
    logic    pop;

    always_comb
    begin
        pop  = head_v_reg && out_ch.ready;
        take = offer && !spare_v_reg && (!head_v_reg || pop);

        head_v_next  = head_v_reg && !pop;
        head_next    = head_reg;
        spare_v_next = spare_v_reg;
        spare_next   = spare_reg;

        if (spare_v_reg && pop)
        begin
            head_v_next  = 1'b1;
            head_next    = spare_reg;
            spare_v_next = 1'b0;
        end
        else if (take && res.count != 2'd0)
        begin
            head_v_next = 1'b1;
            head_next   = res.first;
            if (res.count == 2'd2)
            begin
                spare_v_next = 1'b1;
                spare_next   = res.second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_v_reg  <= 1'b0;
            spare_v_reg <= 1'b0;
        end
        else
        begin
            head_v_reg  <= head_v_next;
            spare_v_reg <= spare_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign out_ch.valid    = head_v_reg;
    assign out_ch.out_byte = head_reg.out_byte;
    assign out_ch.out_last = head_reg.out_last;
    assign out_ch.forward  = head_reg.forward;

    // The spare register is only ever filled behind a full head.
    assert property (@(posedge clk) disable iff (!rst_n)
        spare_v_reg |-> head_v_reg)
        else $error("spare result held with an empty head");

    // A held second result blocks the edit stage until it moves up.
    assert property (@(posedge clk) disable iff (!rst_n)
        spare_v_reg |-> !take)
        else $error("new word taken while a second result is pending");

endmodule

FILE: tb/sv/tb_ttl_match_decrement_rewriter_core.sv
// ============================================================================
// TTL rewriter core testbench
// Streams Ethernet frames through the core one byte per word and checks
// every returned word against a cycle-free predictor. The predictor tracks
// the frame layout, the TTL rule and the incremental checksum patch.
// Directed frames come first, then phases of random frames, each phase
// under its own TTL rule and one of four patterns of source and sink idling.
// ============================================================================
module tb_ttl_match_decrement_rewriter_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ttlr_pkg::*;

    // Cycles to let pass after the last expected word before the core is
    // treated as idle. The result path is two registers deep, plus the
    // spare register for the second checksum word.
    localparam int SETTLE_CYCLES = 8;
    // Random bytes per phase; with the directed frames, eight phases give
    // roughly 1050 bytes in all.
    localparam int PHASE_BYTES = 45;
    localparam int NUM_PHASES  = 8;

    logic clk;
    logic rst_n;

    ttlr_in_if  in_ch ();
    ttlr_out_if out_ch ();
    ttlr_cfg_if cfg_ch ();

    ttl_match_decrement_rewriter_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Words the core still owes us, oldest first.
    result_t expected_words[$];
    // Frame under construction, sent as a whole by send_frame.
    item_t frame_bytes[$];

    int unsigned fail_count     = 0;
    int unsigned items_sent     = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    // Predictor copy of the TTL rule registers.
    logic [ByteW-1:0] rule_match  = MATCH_TTL_RESET;
    logic [ByteW-1:0] rule_lowest = LOWEST_TTL_RESET;

    // Predictor copy of the per-frame tracking state.
    logic [PosW-1:0]  trk_pos;
    logic             trk_vlan;
    logic [ByteW-1:0] trk_type_hi;
    logic             trk_ipv4;
    logic             trk_ttl_hit;
    logic             trk_trunc;
    logic [ByteW-1:0] trk_cksum_hi;
    logic             trk_patched;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic result_t mk_word(input logic [ByteW-1:0] b, input logic last,
                                        input logic fwd);
        result_t r;
        r.out_byte = b;
        r.out_last = last;
        r.forward  = fwd;
        return r;
    endfunction

    // Everything but the registers and the held checksum byte goes back to
    // its reset value at the end of each frame.
    task automatic clear_tracking();
        trk_pos     = '0;
        trk_vlan    = 1'b0;
        trk_type_hi = '0;
        trk_ipv4    = 1'b0;
        trk_ttl_hit = 1'b0;
        trk_trunc   = 1'b0;
        trk_patched = 1'b0;
    endtask

    // Works out the words that one accepted input byte produces and queues
    // them: none for the first checksum byte of a frame that goes on, two
    // for the second checksum byte, one otherwise.
    task automatic predict_rewrite(input item_t w);
        logic [PosW-1:0]  pos;
        logic [PosW-1:0]  ip_base;
        logic [ByteW-1:0] ob;
        logic [ByteW-1:0] hi;
        logic [ByteW-1:0] lo;
        logic [16:0]      sum;
        logic             fwd;
        pos     = trk_pos;
        ip_base = trk_vlan ? PLAIN_IP_BASE + TAG_BYTES : PLAIN_IP_BASE;
        ob      = w.in_byte;

        if (w.truncated)
            trk_trunc = 1'b1;

        if (pos == TYPE_HI_POS || (trk_vlan && pos == TYPE_HI_POS + TAG_BYTES))
            trk_type_hi = w.in_byte;

        // Outer ethertype may announce one tag; a tag behind it is not
        // followed, so only IPv4 counts at the inner position.
        if (pos == TYPE_LO_POS)
        begin
            if ({trk_type_hi, w.in_byte} == TAG_ETHERTYPE)
                trk_vlan = 1'b1;
            else if ({trk_type_hi, w.in_byte} == IPV4_ETHERTYPE)
                trk_ipv4 = 1'b1;
        end
        else if (trk_vlan && pos == TYPE_LO_POS + TAG_BYTES)
        begin
            if ({trk_type_hi, w.in_byte} == IPV4_ETHERTYPE)
                trk_ipv4 = 1'b1;
        end

        if (trk_ipv4 && pos == ip_base + TTL_OFFSET)
        begin
            if (w.in_byte == rule_match && w.in_byte >= rule_lowest && !trk_trunc)
            begin
                trk_ttl_hit = 1'b1;
                ob = w.in_byte - 8'd1;
            end
        end

        if (trk_ipv4 && pos == ip_base + CHECK_HI_OFFSET)
        begin
            // The high checksum byte is held back; only a frame that ends
            // right here gets it back, unedited and never forwarded.
            trk_cksum_hi = w.in_byte;
            if (!w.in_last)
                trk_pos = pos + 5'd1;
            else
            begin
                expected_words.push_back(mk_word(w.in_byte, 1'b1, 1'b0));
                clear_tracking();
            end
        end
        else
        begin
            if (trk_ipv4 && pos == ip_base + CHECK_LO_OFFSET)
            begin
                hi = trk_cksum_hi;
                lo = w.in_byte;
                if (trk_ttl_hit)
                begin
                    // Incremental patch with the end-around fold at 0xFFFF.
                    sum = {1'b0, trk_cksum_hi, w.in_byte} + TTL_STEP;
                    if (sum >= CHECK_FOLD)
                        sum = sum + 17'd1;
                    hi = sum[15:8];
                    lo = sum[7:0];
                    trk_patched = 1'b1;
                end
                expected_words.push_back(mk_word(hi, 1'b0, 1'b0));
                ob = lo;
            end

            fwd = w.in_last && trk_ttl_hit && trk_patched && !trk_trunc;
            expected_words.push_back(mk_word(ob, w.in_last, fwd));

            if (w.in_last)
                clear_tracking();
            else if (pos < POS_MAX)
                trk_pos = pos + 5'd1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The slowest legal run stays far below this; hitting it means a hang.
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random backpressure and a field by field check of every
    // accepted word against the oldest expectation.
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin
        result_t got;
        result_t want;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            // Values read here are the ones the core saw at this edge.
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.out_byte = out_ch.out_byte;
                got.out_last = out_ch.out_last;
                got.forward  = out_ch.forward;
                if (expected_words.size() == 0)
                begin
                    $error("word with no expectation: out_byte 0x%0h out_last %0d forward %0d",
                           got.out_byte, got.out_last, got.forward);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("out_last", want.out_last, got.out_last);
                    check_field("forward", want.forward, got.forward);
                end
            end
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Input side and configuration port
    // ------------------------------------------------------------------------

    // Offers one byte, with random idle cycles in front of it, and returns at
    // the edge where the core takes it. valid is left high so that the next
    // byte can follow back to back.
    task automatic send_word(input item_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= w.in_byte;
        in_ch.in_last   <= w.in_last;
        in_ch.truncated <= w.truncated;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_rewrite(w);
        items_sent++;
    endtask

    // Stops offering bytes and waits until every expected word is back and
    // the pipeline has had time to empty.
    task automatic drain_all();
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [ByteW-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MATCH_TTL:  rule_match  = value;
            CFG_LOWEST_TTL: rule_lowest = value;
            default: ;
        endcase
    endtask

    // New TTL rule, written only with the core idle between frames.
    task automatic set_ttl_rule(input logic [ByteW-1:0] match, input logic [ByteW-1:0] lowest);
        drain_all();
        write_reg(CFG_MATCH_TTL, match);
        write_reg(CFG_LOWEST_TTL, lowest);
    endtask

    // ------------------------------------------------------------------------
    // Frame construction
    // ------------------------------------------------------------------------

    // Fills frame_bytes with len random bytes, then places the ethertype
    // (behind one VLAN header when with_vlan is set), the TTL and the
    // checksum where the IP header puts them. trunc_at marks one byte as
    // truncated, or none if -1.
    task automatic make_frame(input bit with_vlan, input logic [15:0] etype,
                              input logic [ByteW-1:0] ttl, input logic [15:0] cksum,
                              input int len, input int trunc_at);
        int    ip_at;
        item_t w;
        frame_bytes.delete();
        ip_at = with_vlan ? 18 : 14;
        for (int i = 0; i < len; i++)
        begin
            w.in_byte = 8'($urandom_range(255));
            if (with_vlan)
            begin
                if (i == 12) w.in_byte = TAG_ETHERTYPE[15:8];
                if (i == 13) w.in_byte = TAG_ETHERTYPE[7:0];
                if (i == 16) w.in_byte = etype[15:8];
                if (i == 17) w.in_byte = etype[7:0];
            end
            else
            begin
                if (i == 12) w.in_byte = etype[15:8];
                if (i == 13) w.in_byte = etype[7:0];
            end
            if (i == ip_at + 8)  w.in_byte = ttl;
            if (i == ip_at + 10) w.in_byte = cksum[15:8];
            if (i == ip_at + 11) w.in_byte = cksum[7:0];
            w.in_last   = (i == len - 1);
            w.truncated = (i == trunc_at);
            frame_bytes.push_back(w);
        end
    endtask

    // Sends frame_bytes; at byte pause_at the source holds off until every
    // expected word has come back, even in the middle of the frame.
    task automatic send_frame(input int pause_at);
        foreach (frame_bytes[i])
        begin
            if (i == pause_at)
                drain_all();
            send_word(frame_bytes[i]);
        end
    endtask

    // Mostly well-formed IPv4 frames with random content whose length lands
    // around the checksum bytes; the rest are foreign or nested ethertypes,
    // very short and very long frames, and truncation marks.
    task automatic random_frame();
        int unsigned      kind;
        int unsigned      pick;
        bit               with_vlan;
        logic [15:0]      etype;
        logic [ByteW-1:0] ttl;
        logic [15:0]      cksum;
        int               ip_at;
        int               len;
        int               trunc_at;
        kind      = $urandom_range(99);
        with_vlan = ($urandom_range(99) < 30);
        etype     = IPV4_ETHERTYPE;
        if (kind >= 78)
        begin
            case ($urandom_range(2))
                0: etype = 16'($urandom);
                1:
                begin
                    with_vlan = 1'b1;
                    etype     = TAG_ETHERTYPE;
                end
                default: etype = {IPV4_ETHERTYPE[15:8], 8'($urandom_range(255))};
            endcase
        end

        if ($urandom_range(99) < 65)
            ttl = rule_match;
        else
            ttl = 8'($urandom_range(255));

        // Bias the checksum toward the fold region now and then.
        if ($urandom_range(99) < 20)
            cksum = {7'h7F, 1'($urandom_range(1)), 8'($urandom_range(255))};
        else
            cksum = 16'($urandom);

        ip_at = with_vlan ? 18 : 14;
        pick  = $urandom_range(99);
        if (pick < 15)
            len = $urandom_range(ip_at + 11, 1);
        else if (pick < 82)
            len = $urandom_range(ip_at + 16, ip_at + 12);
        else
            len = $urandom_range(64, ip_at + 17);

        trunc_at = ($urandom_range(99) < 12) ? int'($urandom_range(len - 1)) : -1;

        make_frame(with_vlan, etype, ttl, cksum, len, trunc_at);
        send_frame(($urandom_range(99) < 4) ? int'($urandom_range(len - 1)) : -1);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Right after reset the rule must be TTL 64 with a floor of 15.
    task automatic test_reset_rule();
        make_frame(1'b0, IPV4_ETHERTYPE, MATCH_TTL_RESET, 16'h1234, 26, -1);
        send_frame(-1);
        make_frame(1'b0, IPV4_ETHERTYPE, MATCH_TTL_RESET - 8'd1, 16'h00FF, 26, -1);
        send_frame(-1);
    endtask

    // VLAN IPv4, a VLAN header behind another, and a foreign ethertype.
    task automatic test_frame_types();
        make_frame(1'b1, IPV4_ETHERTYPE, rule_match, 16'hA5A5, 30, -1);
        send_frame(-1);
        make_frame(1'b1, TAG_ETHERTYPE, rule_match, 16'h5A5A, 30, -1);
        send_frame(-1);
        make_frame(1'b0, 16'h0806, rule_match, 16'hFFFF, 26, -1);
        send_frame(-1);
    endtask

    // TTL below the floor, TTL zero wrapping to 255, and the checksum fold.
    task automatic test_ttl_rules();
        set_ttl_rule(8'd10, 8'd20);
        make_frame(1'b0, IPV4_ETHERTYPE, 8'd10, 16'h4000, 26, -1);
        send_frame(-1);
        set_ttl_rule(8'd0, 8'd0);
        make_frame(1'b0, IPV4_ETHERTYPE, 8'd0, 16'hFEFF, 26, -1);
        send_frame(-1);
        set_ttl_rule(8'd255, 8'd255);
        make_frame(1'b1, IPV4_ETHERTYPE, 8'd255, 16'hFFFF, 30, -1);
        send_frame(-1);
        set_ttl_rule(8'd255, 8'd0);
        make_frame(1'b0, IPV4_ETHERTYPE, 8'd255, 16'hFEFE, 26, -1);
        send_frame(-1);
    endtask

    // Frames ending on either checksum byte or long before it, and
    // truncation marks before the TTL, after it and on the last byte.
    task automatic test_short_and_truncated();
        set_ttl_rule(MATCH_TTL_RESET, LOWEST_TTL_RESET);
        make_frame(1'b0, IPV4_ETHERTYPE, rule_match, 16'hC0DE, 25, -1);
        send_frame(-1);
        make_frame(1'b0, IPV4_ETHERTYPE, rule_match, 16'hBEEF, 26, -1);
        // Pause between the two checksum bytes, while one is held back.
        send_frame(25);
        make_frame(1'b0, IPV4_ETHERTYPE, rule_match, 16'h0000, 5, -1);
        send_frame(-1);
        make_frame(1'b0, IPV4_ETHERTYPE, rule_match, 16'h1111, 26, 3);
        send_frame(-1);
        make_frame(1'b0, IPV4_ETHERTYPE, rule_match, 16'h2222, 26, 24);
        send_frame(-1);
        make_frame(1'b1, IPV4_ETHERTYPE, rule_match, 16'h3333, 32, 31);
        send_frame(-1);
    endtask

    // The byte counter saturates well past the edited bytes.
    task automatic test_long_frame();
        make_frame(1'b0, IPV4_ETHERTYPE, rule_match, 16'h7777, 48, -1);
        send_frame(-1);
    endtask

    // Phases of random frames. Each phase gets its own rule, some of them
    // at the extremes, and cycles through the idling patterns.
    task automatic test_random_traffic();
        int unsigned      start;
        logic [ByteW-1:0] match;
        logic [ByteW-1:0] lowest;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    match  = 8'd255;
                    lowest = 8'd0;
                end
                3:
                begin
                    match  = 8'd0;
                    lowest = 8'd0;
                end
                5:
                begin
                    match  = 8'd255;
                    lowest = 8'd255;
                end
                default:
                begin
                    match  = 8'($urandom_range(255));
                    lowest = ($urandom_range(99) < 80) ? 8'($urandom_range(match))
                                                        : 8'($urandom_range(255));
                end
            endcase
            set_ttl_rule(match, lowest);

            case (ph % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 79;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 79;
                end
                default:
                begin
                    src_idle_pct   = 19;
                    sink_stall_pct = 19;
                end
            endcase

            start = items_sent;
            while (items_sent - start < PHASE_BYTES)
                random_frame();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.in_byte    <= '0;
        in_ch.in_last    <= 1'b0;
        in_ch.truncated  <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.reg_index <= CFG_MATCH_TTL;
        cfg_ch.wr_data   <= '0;
        clear_tracking();
        trk_cksum_hi = '0;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_rule();
        test_frame_types();
        test_ttl_rules();
        test_short_and_truncated();
        test_long_frame();

        // Directed part again under idling, so that gaps hit the
        // checksum hold and the two-word drain.
        src_idle_pct   = 19;
        sink_stall_pct = 19;
        test_short_and_truncated();

        test_random_traffic();

        // The source stops here; wait for the last words, then let the
        // pipeline settle so that a stray extra word would still be seen.
        drain_all();

        if (fail_count == 0 && expected_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
